>>> sv/ist_pkg.sv
// Shared types and constants for the integer set table.
package ist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 3;
    localparam int COUNT_W      = 7;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_TOGGLE = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic clr_all;
        logic drop;
        logic add;
    } t_cam_op;

    typedef struct packed {
        logic hit;
        logic full;
    } t_cam_stat;

endpackage

>>> sv/ist_cam.sv
// Content-addressed entry store with parallel match and lowest-free-entry select.
module ist_cam #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ist_pkg::VALUE_W-1:0]  i_key,
    input  ist_pkg::t_cam_op             i_op,
    output ist_pkg::t_cam_stat           o_stat
);
    import ist_pkg::*;

    logic [VALUE_W-1:0]  r_value [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] n_valid;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_free;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = r_valid[i] && (r_value[i] == i_key);
        end
        // Lowest clear bit of the valid vector.
        w_free      = ~r_valid & (r_valid + CAPACITY'(1));
        o_stat.hit  = |w_match;
        o_stat.full = &r_valid;
    end

    always_comb begin
        if (i_op.clr_all) begin
            n_valid = '0;
        end else begin
            n_valid = r_valid;
            if (i_op.drop) begin
                n_valid = n_valid & ~w_match;
            end
            if (i_op.add) begin
                n_valid = n_valid | w_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_op.add && w_free[i]) begin
                r_value[i] <= i_key;
            end
        end
    end

endmodule

>>> sv/integer_set_table.sv
// Top level of the integer set table: input register, command decode, result register.
// A word waits in the input register until the result register is empty or being read.
// Throughput: one word per cycle while results are taken; the parallel match over all
// entries and the lowest-free-entry select are combinational between the two registers.
// Reset clears all valid bits, the member count and both handshake stages.
module integer_set_table #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // Fields from bit 0: cmd [2:0], value [34:3], zero fill [39:35].
    input  logic [ist_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // Fields from bit 0: was_present [0], changed [1], full_refused [2],
    // member_count [9:3], zero fill [15:10].
    output logic [ist_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import ist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_cmd;
    logic [VALUE_W-1:0]    r_value;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic      w_advance;
    logic      w_in_take;
    logic      w_changed;
    logic      w_refused;
    t_cam_op   w_dec;
    t_cam_op   w_op;
    t_cam_stat w_stat;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op            = w_advance ? w_dec : '0;

    ist_cam #(
        .CAPACITY (CAPACITY)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_value),
        .i_op    (w_op),
        .o_stat  (w_stat)
    );

    always_comb begin
        w_dec     = '0;
        w_changed = 1'b0;
        w_refused = 1'b0;
        case (r_cmd)
            CMD_INSERT: begin
                if (!w_stat.hit) begin
                    if (!w_stat.full) begin
                        w_dec.add = 1'b1;
                        w_changed = 1'b1;
                    end else begin
                        w_refused = 1'b1;
                    end
                end
            end
            CMD_ERASE: begin
                if (w_stat.hit) begin
                    w_dec.drop = 1'b1;
                    w_changed  = 1'b1;
                end
            end
            CMD_TOGGLE: begin
                if (w_stat.hit) begin
                    w_dec.drop = 1'b1;
                    w_changed  = 1'b1;
                end else if (!w_stat.full) begin
                    w_dec.add = 1'b1;
                    w_changed = 1'b1;
                end else begin
                    w_refused = 1'b1;
                end
            end
            CMD_CLEAR: begin
                w_dec.clr_all = 1'b1;
                w_changed     = (r_count != '0);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (w_dec.clr_all) begin
            n_count = '0;
        end else if (w_dec.add) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_dec.drop) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd   <= i_s_axis_tdata[CMD_W-1:0];
            r_value <= i_s_axis_tdata[CMD_W +: VALUE_W];
        end
        if (w_advance) begin
            r_out_data <= {{(OUT_DATA_W-3-COUNT_W){1'b0}}, COUNT_W'(n_count),
                           w_refused, w_changed, w_stat.hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> sv/ist_check.sv
// Port-level assertions for the integer set table and the bind that attaches them.
module ist_check #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [ist_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [ist_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import ist_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result word present right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Stalled result word changed.");

    a_refused_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> !o_m_axis_tdata[1] && !o_m_axis_tdata[0])
        else $error("Refused add reported as present or changed.");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> o_m_axis_tdata[9:3] == COUNT_W'(CAPACITY))
        else $error("Add refused while the table was not full.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (CAPACITY > 127) || (int'(o_m_axis_tdata[9:3]) <= CAPACITY))
        else $error("Member count above capacity.");

    logic w_unused;
    assign w_unused = i_s_axis_tvalid ^ o_s_axis_tready ^ (^i_s_axis_tdata);

endmodule

bind integer_set_table ist_check #(
    .CAPACITY (CAPACITY)
) u_ist_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
